/* hw/rtl/rpcd_pkg.sv */
// Shared types, constants and the CRC16-CCITT byte update for the command deframer.
// No dependencies; imported by the parser, job queue, emitter, top and testbench files.
`timescale 1ns / 1ps
package rpcd_pkg;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [6:0]  MAX_EMIT = 7'd64;
   localparam logic [7:0]  NONCE_BYTES = 8'd4;

   localparam logic [2:0] CSR_SYNC_FIRST   = 3'd0;
   localparam logic [2:0] CSR_SYNC_SECOND  = 3'd1;
   localparam logic [2:0] CSR_COMMAND_ID   = 3'd2;
   localparam logic [2:0] CSR_COMMAND_SIZE = 3'd3;
   localparam logic [2:0] CSR_NONCE_OFFSET = 3'd4;

   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
      logic [7:0] command_message_id;
      logic [6:0] command_size;
      logic [5:0] nonce_offset;
   } cfg_type;

   typedef struct packed {
      logic       bank;
      logic [6:0] count;
   } job_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   typedef struct packed {
      logic [7:0] command_byte;
      logic [5:0] byte_position;
      logic       last_byte;
   } rsp_type;

   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

/* hw/rtl/rpcd_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module rpcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/rpcd_front.sv */
// Frame parser: sync hunt, header, payload write into a two-bank buffer, CRC and
// acceptance checks, nonce tracking. Uses rpcd_pkg; feeds rpcd_job_fifo and rpcd_ram.
`timescale 1ns / 1ps
module rpcd_front
   import rpcd_pkg::*;
#(
   parameter int PAYLOAD_DEPTH = 64,
   localparam int IDX_W = $clog2(PAYLOAD_DEPTH),
   localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_push,
   input  logic [7:0]       in_byte,
   output logic             in_full,
   input  cfg_type          cfg,
   output logic             job_push,
   output job_type          job,
   input  release_type      rel,
   output logic             ram_we,
   output logic [IDX_W:0]   ram_waddr,
   output logic [7:0]       ram_wdata
);

   localparam logic [2:0] PH_SYNC1   = 3'd0;
   localparam logic [2:0] PH_SYNC2   = 3'd1;
   localparam logic [2:0] PH_ID      = 3'd2;
   localparam logic [2:0] PH_LEN     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_CHK_HI  = 3'd5;
   localparam logic [2:0] PH_CHK_LO  = 3'd6;

   logic [2:0]       phase_ff, phase_in;
   logic [7:0]       frame_id_ff, frame_id_in;
   logic [CNT_W-1:0] frame_len_ff, frame_len_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       rx_hi_ff, rx_hi_in;
   logic [31:0]      nonce_ff, nonce_in;
   logic [31:0]      newest_ff, newest_in;
   logic             bank_ff, bank_in;
   logic [1:0]       busy_ff, busy_in;

   logic             fire;
   logic             accept;
   logic [CNT_W-1:0] count_next;
   logic [7:0]       cnt8, off8, rel8;

   assign in_full    = (phase_ff == PH_PAYLOAD) && busy_ff[bank_ff];
   assign fire       = in_push && !in_full;
   assign count_next = count_ff + CNT_W'(1);
   assign cnt8       = 8'(count_ff);
   assign off8       = 8'(cfg.nonce_offset);
   assign rel8       = cnt8 - off8;

   assign ram_waddr = {bank_ff, count_ff[IDX_W-1:0]};
   assign ram_wdata = in_byte;
   assign job.bank  = bank_ff;
   assign job.count = (cfg.command_size > MAX_EMIT) ? MAX_EMIT : cfg.command_size;
   assign job_push  = accept;

   always_comb begin
      phase_in     = phase_ff;
      frame_id_in  = frame_id_ff;
      frame_len_in = frame_len_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      rx_hi_in     = rx_hi_ff;
      nonce_in     = nonce_ff;
      newest_in    = newest_ff;
      bank_in      = bank_ff;
      busy_in      = busy_ff;
      accept       = 1'b0;
      ram_we       = 1'b0;
      if (fire) begin
         unique case (phase_ff)
            PH_SYNC2: begin
               phase_in = (in_byte == cfg.sync_second) ? PH_ID : PH_SYNC1;
            end
            PH_ID: begin
               frame_id_in = in_byte;
               crc_in      = crc16_update(CRC_INIT, in_byte);
               phase_in    = PH_LEN;
            end
            PH_LEN: begin
               frame_len_in = CNT_W'(in_byte);
               count_in     = '0;
               crc_in       = crc16_update(crc_ff, in_byte);
               if (in_byte != 8'd0 && in_byte <= 8'(PAYLOAD_DEPTH)) begin
                  phase_in = PH_PAYLOAD;
               end else begin
                  phase_in = PH_SYNC1;
               end
            end
            PH_PAYLOAD: begin
               ram_we   = 1'b1;
               count_in = count_next;
               crc_in   = crc16_update(crc_ff, in_byte);
               if (cnt8 >= off8 && rel8 < NONCE_BYTES) begin
                  nonce_in[8*rel8[1:0] +: 8] = in_byte;
               end
               if (count_next >= frame_len_ff) begin
                  phase_in = PH_CHK_HI;
               end
            end
            PH_CHK_HI: begin
               rx_hi_in = in_byte;
               phase_in = PH_CHK_LO;
            end
            PH_CHK_LO: begin
               phase_in = PH_SYNC1;
               accept = ({rx_hi_ff, in_byte} == crc_ff)
                     && (frame_id_ff == cfg.command_message_id)
                     && (8'(frame_len_ff) >= 8'(cfg.command_size))
                     && (off8 + NONCE_BYTES <= 8'(cfg.command_size))
                     && (nonce_ff > newest_ff);
               if (accept) begin
                  newest_in = nonce_ff;
                  bank_in   = !bank_ff;
               end
            end
            default: begin
               phase_in = (in_byte == cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
            end
         endcase
      end
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (accept) begin
         busy_in[bank_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SYNC1;
         newest_ff <= '0;
         bank_ff   <= 1'b0;
         busy_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         newest_ff <= newest_in;
         bank_ff   <= bank_in;
         busy_ff   <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_id_ff  <= frame_id_in;
      frame_len_ff <= frame_len_in;
      count_ff     <= count_in;
      crc_ff       <= crc_in;
      rx_hi_ff     <= rx_hi_in;
      nonce_ff     <= nonce_in;
   end

endmodule

/* hw/rtl/rpcd_job_fifo.sv */
// Two-entry queue of accepted command runs between the parser and the emitter.
// Uses rpcd_pkg for the job record.
`timescale 1ns / 1ps
module rpcd_job_fifo
   import rpcd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    empty,
   output job_type head
);

   job_type    entry_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign empty   = (cnt_ff == 2'd0);
   assign head    = entry_ff[rp_ff];
   assign do_push = push && (cnt_ff != 2'd2);
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wp_ff <= !wp_ff;
         end
         if (do_pop) begin
            rp_ff <= !rp_ff;
         end
         cnt_ff <= cnt_ff + 2'(do_push) - 2'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wp_ff] <= push_job;
      end
   end

endmodule

/* hw/rtl/rpcd_back.sv */
// Command run emitter: reads a stored payload bank byte by byte into a two-entry
// result queue and frees the bank. Uses rpcd_pkg; reads through rpcd_ram.
`timescale 1ns / 1ps
module rpcd_back
   import rpcd_pkg::*;
#(
   parameter int PAYLOAD_DEPTH = 64,
   localparam int IDX_W = $clog2(PAYLOAD_DEPTH)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           job_empty,
   input  job_type        job,
   output logic           job_pop,
   output logic           ram_re,
   output logic [IDX_W:0] ram_raddr,
   input  logic [7:0]     ram_rdata,
   output release_type    rel,
   output logic           out_empty,
   input  logic           out_pop,
   output rsp_type        out_item
);

   logic       active_ff;
   logic       bank_ff;
   logic [6:0] n_ff;
   logic [5:0] idx_ff;
   logic       inflight_ff;
   logic [5:0] pos_ff;
   logic       last_ff;
   rsp_type    outq_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   logic       pop_fire, issue, last_issue;
   logic [2:0] occupancy;

   assign pop_fire   = out_pop && !out_empty;
   assign occupancy  = 3'(cnt_ff) + 3'(inflight_ff);
   assign issue      = active_ff && ((occupancy < 3'd2) || pop_fire);
   assign last_issue = issue && ((7'(idx_ff) + 7'd1) == n_ff);
   assign job_pop    = !active_ff && !job_empty;

   assign ram_re    = issue;
   assign ram_raddr = {bank_ff, IDX_W'(idx_ff)};
   assign rel.valid = last_issue;
   assign rel.bank  = bank_ff;

   assign out_empty = (cnt_ff == 2'd0);
   assign out_item  = outq_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         inflight_ff <= 1'b0;
         wp_ff       <= 1'b0;
         rp_ff       <= 1'b0;
         cnt_ff      <= 2'd0;
      end else begin
         if (job_pop) begin
            active_ff <= 1'b1;
         end else if (last_issue) begin
            active_ff <= 1'b0;
         end
         inflight_ff <= issue;
         if (inflight_ff) begin
            wp_ff <= !wp_ff;
         end
         if (pop_fire) begin
            rp_ff <= !rp_ff;
         end
         cnt_ff <= cnt_ff + 2'(inflight_ff) - 2'(pop_fire);
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         bank_ff <= job.bank;
         n_ff    <= job.count;
         idx_ff  <= '0;
      end else if (issue) begin
         idx_ff <= idx_ff + 6'd1;
      end
      if (issue) begin
         pos_ff  <= idx_ff;
         last_ff <= last_issue;
      end
      if (inflight_ff) begin
         outq_ff[wp_ff] <= '{command_byte: ram_rdata, byte_position: pos_ff,
                             last_byte: last_ff};
      end
   end

endmodule

/* hw/rtl/replay_protected_command_deframer_top.sv */
// Top level of the replay-protected command deframer: configuration registers and
// the parser, job queue, emitter and payload RAM. Uses rpcd_pkg and those rpcd_ modules.
`timescale 1ns / 1ps
// The block takes one received byte per cycle while full is low and finds frames of two
// sync bytes, an id, a length, the payload and a big-endian CRC16-CCITT. Payloads land in
// one of two banks of a RAM; a frame with a good CRC, the command id, enough length, a
// nonce window inside command_size and a nonce above the last accepted one is queued. Its
// run of min(command_size, 64) beats passes the job queue, the emitter's active flag, the
// RAM read register and the result queue to the result ports, then follows at up to one
// beat per cycle while pops keep up. Full rises only while a payload byte waits for a bank
// whose previous run is still being read out, so the input side stalls only when a second
// frame is accepted and a third reaches its payload before the first run is read out.
module replay_protected_command_deframer_top
   import rpcd_pkg::*;
#(
   parameter int PAYLOAD_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_rx_byte,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_command_byte,
   output logic [5:0] rsp_byte_position,
   output logic       rsp_last_byte,
   input  logic       valid,
   output logic       ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);

   localparam int IDX_W     = $clog2(PAYLOAD_DEPTH);
   localparam int RAM_DEPTH = 2 << IDX_W;

   cfg_type        cfg_ff;
   logic           job_push, job_pop, job_empty;
   job_type        job_in, job_head;
   release_type    rel;
   logic           ram_we, ram_re;
   logic [IDX_W:0] ram_waddr, ram_raddr;
   logic [7:0]     ram_wdata, ram_rdata;
   rsp_type        rsp_item;

   assign ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first         <= 8'hAA;
         cfg_ff.sync_second        <= 8'h55;
         cfg_ff.command_message_id <= 8'h00;
         cfg_ff.command_size       <= 7'd16;
         cfg_ff.nonce_offset       <= 6'd0;
      end else if (valid && ready) begin
         unique case (csr_index)
            CSR_SYNC_FIRST:   cfg_ff.sync_first <= csr_data;
            CSR_SYNC_SECOND:  cfg_ff.sync_second <= csr_data;
            CSR_COMMAND_ID:   cfg_ff.command_message_id <= csr_data;
            CSR_COMMAND_SIZE: cfg_ff.command_size <= csr_data[6:0];
            CSR_NONCE_OFFSET: cfg_ff.nonce_offset <= csr_data[5:0];
            default: begin
            end
         endcase
      end
   end

   rpcd_front #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_push   (push),
      .in_byte   (req_rx_byte),
      .in_full   (full),
      .cfg       (cfg_ff),
      .job_push  (job_push),
      .job       (job_in),
      .rel       (rel),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata)
   );

   rpcd_job_fifo u_jobs (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job_in),
      .pop      (job_pop),
      .empty    (job_empty),
      .head     (job_head)
   );

   rpcd_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   rpcd_back #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (job_head),
      .job_pop   (job_pop),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .rel       (rel),
      .out_empty (empty),
      .out_pop   (pop),
      .out_item  (rsp_item)
   );

   assign rsp_command_byte  = rsp_item.command_byte;
   assign rsp_byte_position = rsp_item.byte_position;
   assign rsp_last_byte     = rsp_item.last_byte;

endmodule

/* hw/rtl/rpcd_checker.sv */
// Port-level checks on the command deframer's result runs and reset behavior,
// bound to replay_protected_command_deframer_top. No package dependency.
`timescale 1ns / 1ps
module rpcd_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_command_byte,
   input logic [5:0] rsp_byte_position,
   input logic       rsp_last_byte
);

   logic [5:0] expect_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_pos_ff <= 6'd0;
      end else if (pop && !empty) begin
         expect_pos_ff <= rsp_last_byte ? 6'd0 : rsp_byte_position + 6'd1;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not cleared by reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_command_byte)
                            && $stable(rsp_byte_position) && $stable(rsp_last_byte)))
      else $error("waiting result beat changed");

   a_position_order: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_byte_position == expect_pos_ff))
      else $error("result beat out of sequence within a run");

   a_run_length: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_last_byte) |-> (rsp_byte_position >= 6'd3))
      else $error("run shorter than a nonce");

endmodule

bind replay_protected_command_deframer_top rpcd_checker u_rpcd_checker (.*);

/* test/command_deframer_checker.sv */
`timescale 1ns / 1ps
// Checker for the replay-protected command deframer: it follows the byte, result and
// register channels, predicts every command run and compares it beat by beat.
// Depends on rpcd_pkg for the register index constants.
module command_deframer_checker
   import rpcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic       full,
   input  logic [7:0] rx_byte,
   input  logic       empty,
   input  logic       pop,
   input  logic [7:0] command_byte,
   input  logic [5:0] byte_position,
   input  logic       last_byte,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data,
   output int         mismatches,
   output int         pending_beats,
   output int         beats_checked,
   output int         runs_predicted
);

   localparam int          STORE_DEPTH = 64;
   localparam logic [15:0] CCITT_POLY = 16'h1021;
   localparam logic [15:0] CCITT_SEED = 16'hFFFF;
   localparam logic [7:0]  RESET_SYNC_FIRST = 8'hAA;
   localparam logic [7:0]  RESET_SYNC_SECOND = 8'h55;
   localparam logic [7:0]  RESET_COMMAND_ID = 8'h00;
   localparam logic [6:0]  RESET_COMMAND_SIZE = 7'd16;
   localparam logic [5:0]  RESET_NONCE_OFFSET = 6'd0;

   localparam logic [2:0] HUNT_FIRST   = 3'd0;
   localparam logic [2:0] HUNT_SECOND  = 3'd1;
   localparam logic [2:0] TAKE_ID      = 3'd2;
   localparam logic [2:0] TAKE_LENGTH  = 3'd3;
   localparam logic [2:0] TAKE_PAYLOAD = 3'd4;
   localparam logic [2:0] TAKE_CRC_HI  = 3'd5;
   localparam logic [2:0] TAKE_CRC_LO  = 3'd6;

   typedef struct packed {
      logic [7:0] value;
      logic [5:0] position;
      logic       is_last;
   } command_beat_type;

   logic [7:0]       sync_first_reg;
   logic [7:0]       sync_second_reg;
   logic [7:0]       command_id_reg;
   logic [6:0]       command_size_reg;
   logic [5:0]       nonce_offset_reg;
   logic [2:0]       state;
   logic [7:0]       frame_id;
   logic [7:0]       frame_length;
   int               payload_count;
   logic [7:0]       payload [STORE_DEPTH];
   logic [15:0]      crc_running;
   logic [15:0]      crc_received;
   logic [31:0]      newest_nonce;
   command_beat_type expected_beats [$];

   function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      int          k;
      r = acc ^ {b, 8'h00};
      for (k = 0; k < 8; k++) begin
         r = r[15] ? ({r[14:0], 1'b0} ^ CCITT_POLY) : {r[14:0], 1'b0};
      end
      return r;
   endfunction

   task automatic take_byte(input logic [7:0] b);
      logic [31:0] nonce;
      int          i;
      unique case (state)
         HUNT_SECOND: begin
            if (b == sync_second_reg) state = TAKE_ID;
            else state = HUNT_FIRST;
         end
         TAKE_ID: begin
            frame_id = b;
            crc_running = crc_step(CCITT_SEED, b);
            state = TAKE_LENGTH;
         end
         TAKE_LENGTH: begin
            frame_length = b;
            payload_count = 0;
            crc_running = crc_step(crc_running, b);
            if (b >= 1 && b <= STORE_DEPTH) state = TAKE_PAYLOAD;
            else state = HUNT_FIRST;
         end
         TAKE_PAYLOAD: begin
            payload[payload_count] = b;
            payload_count++;
            crc_running = crc_step(crc_running, b);
            if (payload_count >= frame_length) state = TAKE_CRC_HI;
         end
         TAKE_CRC_HI: begin
            crc_received[15:8] = b;
            state = TAKE_CRC_LO;
         end
         TAKE_CRC_LO: begin
            crc_received[7:0] = b;
            state = HUNT_FIRST;
            if (crc_received == crc_running && frame_id == command_id_reg &&
                frame_length >= command_size_reg &&
                int'(nonce_offset_reg) + 4 <= int'(command_size_reg)) begin
               nonce = {payload[nonce_offset_reg + 3], payload[nonce_offset_reg + 2],
                        payload[nonce_offset_reg + 1], payload[nonce_offset_reg]};
               if (nonce > newest_nonce) begin
                  newest_nonce = nonce;
                  runs_predicted++;
                  for (i = 0; i < int'(command_size_reg); i++) begin
                     expected_beats.push_back({payload[i], 6'(i),
                                               i == int'(command_size_reg) - 1});
                  end
               end
            end
         end
         default: begin
            if (b == sync_first_reg) state = HUNT_SECOND;
            else state = HUNT_FIRST;
         end
      endcase
   endtask

   task automatic check_beat();
      command_beat_type want;
      if (expected_beats.size() == 0) begin
         mismatches++;
         $display("%0t: beat expected none, actual byte %02h position %0d last %0b",
                  $time, command_byte, byte_position, last_byte);
      end else begin
         want = expected_beats.pop_front();
         beats_checked++;
         if (command_byte !== want.value) begin
            mismatches++;
            $display("%0t: command_byte expected %02h, actual %02h",
                     $time, want.value, command_byte);
         end
         if (byte_position !== want.position) begin
            mismatches++;
            $display("%0t: byte_position expected %0d, actual %0d",
                     $time, want.position, byte_position);
         end
         if (last_byte !== want.is_last) begin
            mismatches++;
            $display("%0t: last_byte expected %0b, actual %0b",
                     $time, want.is_last, last_byte);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sync_first_reg = RESET_SYNC_FIRST;
         sync_second_reg = RESET_SYNC_SECOND;
         command_id_reg = RESET_COMMAND_ID;
         command_size_reg = RESET_COMMAND_SIZE;
         nonce_offset_reg = RESET_NONCE_OFFSET;
         state = HUNT_FIRST;
         frame_id = 8'h00;
         frame_length = 8'h00;
         payload_count = 0;
         crc_received = 16'h0000;
         crc_running = CCITT_SEED;
         newest_nonce = 32'h0000_0000;
         expected_beats.delete();
      end else begin
         if (pop && !empty) check_beat();
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SYNC_FIRST:   sync_first_reg = csr_data;
               CSR_SYNC_SECOND:  sync_second_reg = csr_data;
               CSR_COMMAND_ID:   command_id_reg = csr_data;
               CSR_COMMAND_SIZE: command_size_reg = csr_data[6:0];
               CSR_NONCE_OFFSET: nonce_offset_reg = csr_data[5:0];
               default: ;
            endcase
         end
         if (push && !full) take_byte(rx_byte);
      end
      pending_beats <= expected_beats.size();
   end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Top of the command deframer testbench: clock, reset, byte and register stimulus,
// result-side stalls and the verdict. Depends on rpcd_pkg, the block and the checker.
module testbench;
   import rpcd_pkg::*;

   localparam int         SETTLE_CYCLES = 16;
   localparam int         LONG_HOLD_CYCLES = 400;
   localparam int         TIME_LIMIT_NS = 2_000_000;
   localparam logic [2:0] CSR_SPARE = 3'd7;

   logic       clock = 1'b0;
   logic       reset;
   logic       push;
   logic       full;
   logic [7:0] req_rx_byte;
   logic       empty;
   logic       pop;
   logic [7:0] rsp_command_byte;
   logic [5:0] rsp_byte_position;
   logic       rsp_last_byte;
   logic       csr_valid;
   logic       csr_ready;
   logic [2:0] csr_index;
   logic [7:0] csr_data;

   int mismatches;
   int pending_beats;
   int beats_checked;
   int runs_predicted;
   int bytes_sent;
   int frames_sent;
   int settings_used;
   bit quiet_tail;
   bit hold_requested;
   bit hold_done;

   logic [7:0]  cur_sync_first;
   logic [7:0]  cur_sync_second;
   logic [7:0]  cur_id;
   logic [6:0]  cur_size;
   logic [5:0]  cur_offset;
   logic [31:0] nonce_source;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   replay_protected_command_deframer_top dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_rx_byte       (req_rx_byte),
      .empty             (empty),
      .pop               (pop),
      .rsp_command_byte  (rsp_command_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last_byte     (rsp_last_byte),
      .valid             (csr_valid),
      .ready             (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   command_deframer_checker command_check (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .rx_byte        (req_rx_byte),
      .empty          (empty),
      .pop            (pop),
      .command_byte   (rsp_command_byte),
      .byte_position  (rsp_byte_position),
      .last_byte      (rsp_last_byte),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatches     (mismatches),
      .pending_beats  (pending_beats),
      .beats_checked  (beats_checked),
      .runs_predicted (runs_predicted)
   );

   initial begin
      #(TIME_LIMIT_NS);
      $display("%0t: timed out with %0d beats outstanding", $time, pending_beats);
      $display("FAIL");
      $finish;
   end

   // The receiver stalls in short bursts, and once for a long stretch so that both
   // payload banks stay busy and the block has to hold off new bytes.
   initial begin : receiver
      int span;
      pop <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_requested && !hold_done) begin
            hold_done = 1'b1;
            pop <= 1'b0;
            span = LONG_HOLD_CYCLES;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            pop <= 1'b0;
            span = $urandom_range(1, 8);
         end else begin
            pop <= 1'b1;
            span = quiet_tail ? 1 : $urandom_range(1, 12);
         end
         repeat (span) @(posedge clock);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      push <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (full);
      bytes_sent++;
   endtask

   task automatic settle();
      push <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] id,
                            input logic [7:0] size_data, input logic [7:0] offset_data);
      settle();
      write_reg(CSR_SYNC_FIRST, s1);
      write_reg(CSR_SYNC_SECOND, s2);
      write_reg(CSR_COMMAND_ID, id);
      write_reg(CSR_COMMAND_SIZE, size_data);
      write_reg(CSR_NONCE_OFFSET, offset_data);
      write_reg(CSR_SPARE, 8'($urandom));
      csr_valid <= 1'b0;
      cur_sync_first = s1;
      cur_sync_second = s2;
      cur_id = id;
      cur_size = size_data[6:0];
      cur_offset = offset_data[5:0];
      settings_used++;
   endtask

   // Builds a frame with the current sync bytes, a random payload carrying the nonce
   // at the current offset and a CRC over id, length and payload. Bad lengths send
   // the header only; a cut frame stops somewhere before its end.
   task automatic send_frame(input logic [7:0] id, input logic [7:0] length_byte,
                             input logic [31:0] nonce, input bit spoil_crc,
                             input bit cut_short);
      logic [7:0]  frame [$];
      logic [7:0]  b;
      logic [15:0] crc;
      int          body_length;
      int          keep;
      int          i;
      body_length = (length_byte >= 1 && length_byte <= 64) ? length_byte : 0;
      frame.push_back(cur_sync_first);
      frame.push_back(cur_sync_second);
      frame.push_back(id);
      frame.push_back(length_byte);
      crc = crc16_update(CRC_INIT, id);
      crc = crc16_update(crc, length_byte);
      for (i = 0; i < body_length; i++) begin
         b = 8'($urandom);
         if (i >= cur_offset && i < cur_offset + 4) b = nonce[8 * (i - cur_offset) +: 8];
         crc = crc16_update(crc, b);
         frame.push_back(b);
      end
      if (body_length > 0) begin
         if (spoil_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
         frame.push_back(crc[15:8]);
         frame.push_back(crc[7:0]);
      end
      keep = cut_short ? $urandom_range(1, frame.size() - 1) : frame.size();
      for (i = 0; i < keep; i++) send_byte(frame[i]);
      frames_sent++;
   endtask

   task automatic random_frame();
      int pick;
      int length;
      int shortest;
      pick = $urandom_range(0, 99);
      length = cur_size + $urandom_range(0, 3);
      if (length > 64) length = 64;
      if (length < 1) length = 1;
      shortest = (cur_size > 65) ? 64 : cur_size - 1;
      if (pick < 60) begin
         nonce_source = nonce_source + $urandom_range(1, 5000);
         send_frame(cur_id, 8'(length), nonce_source, 1'b0, 1'b0);
      end else if (pick < 68) begin
         send_frame(cur_id, 8'(length), nonce_source - $urandom_range(0, 2), 1'b0, 1'b0);
      end else if (pick < 75) begin
         nonce_source = nonce_source + $urandom_range(1, 5000);
         send_frame(cur_id, 8'(length), nonce_source, 1'b1, 1'b0);
      end else if (pick < 81) begin
         send_frame(cur_id ^ (8'h01 << $urandom_range(0, 7)), 8'(length), nonce_source + 1,
                    1'b0, 1'b0);
      end else if (pick < 86) begin
         if (cur_size > 1) length = $urandom_range(1, shortest);
         send_frame(cur_id, 8'(length), nonce_source + 1, 1'b0, 1'b0);
      end else if (pick < 91) begin
         length = $urandom_range(0, 1) ? 0 : $urandom_range(65, 255);
         send_frame(cur_id, 8'(length), nonce_source + 1, 1'b0, 1'b0);
      end else if (pick < 96) begin
         if ($urandom_range(0, 1)) send_byte(cur_sync_first);
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else begin
         send_frame(cur_id, 8'(length), nonce_source + 1, 1'b0, 1'b1);
      end
   endtask

   task automatic run_phase(input int budget);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < budget) random_frame();
   endtask

   initial begin : stimulus
      int sz;
      reset <= 1'b1;
      push <= 1'b0;
      req_rx_byte <= 8'h00;
      csr_valid <= 1'b0;
      csr_index <= CSR_SYNC_FIRST;
      csr_data <= 8'h00;
      nonce_source = 32'h0000_0000;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      configure(8'hAA, 8'h55, 8'h00, 8'd4, 8'd0);
      send_frame(8'h00, 8'd4, 32'h0000_FF00, 1'b0, 1'b0);
      nonce_source = 32'h0000_FF00;
      // A repeated first sync byte in the second slot must not restart the frame.
      send_byte(8'hAA);
      send_byte(8'hAA);
      send_byte(8'h55);
      send_frame(8'h00, 8'd0, nonce_source, 1'b0, 1'b0);
      send_frame(8'h00, 8'd65, nonce_source, 1'b0, 1'b0);

      configure(8'($urandom), 8'($urandom), 8'($urandom), 8'd8, 8'($urandom_range(0, 4)));
      run_phase(8);

      // Three good frames while the receiver holds off: the first run stays in its
      // bank, the second fills the other bank and the third has to wait.
      configure(8'hFF, 8'h00, 8'hFF, 8'h84, 8'hC0);
      hold_requested = 1'b1;
      repeat (3) begin
         nonce_source = nonce_source + $urandom_range(1, 5000);
         send_frame(cur_id, 8'd4, nonce_source, 1'b0, 1'b0);
      end

      configure(8'($urandom), 8'($urandom), 8'($urandom), 8'd64, 8'd60);
      nonce_source = nonce_source + $urandom_range(1, 5000);
      send_frame(cur_id, 8'd64, nonce_source, 1'b0, 1'b0);

      configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(0, 3)), 8'd0);
      run_phase(6);

      configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(65, 127)),
                8'($urandom_range(0, 60)));
      nonce_source = nonce_source + $urandom_range(1, 5000);
      send_frame(cur_id, 8'd64, nonce_source, 1'b0, 1'b0);

      sz = $urandom_range(4, 16);
      configure(8'($urandom), 8'($urandom), 8'($urandom), 8'(sz),
                8'($urandom_range(0, sz - 4)));
      run_phase(8);

      configure(8'h00, 8'hFF, 8'h00, 8'd6, 8'd2);
      quiet_tail = 1'b1;
      run_phase(10);
      send_frame(cur_id, 8'd6, 32'hFFFF_FFFF, 1'b0, 1'b0);
      nonce_source = 32'hFFFF_FFFF;
      run_phase(4);

      settle();
      $display("Sent %0d bytes in %0d frames plus noise over %0d register settings.",
               bytes_sent, frames_sent, settings_used);
      $display("Compared %0d result beats from %0d accepted command runs, %0d mismatches.",
               beats_checked, runs_predicted, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
